@@ src/rrtp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrtp_pkg
// Shared constants, codes and control/status types of the round-robin picker.
// ----------------------------------------------------------------------------
package rrtp_pkg;

  localparam int MaxTasksDef = 32;

  localparam int ActionW  = 2;
  localparam int TaskIdxW = 5;
  localparam int StatusW  = 2;
  localparam int RcW      = 2;

  localparam logic [ActionW-1:0] ACT_ADD    = 2'd0;
  localparam logic [ActionW-1:0] ACT_SET    = 2'd1;
  localparam logic [ActionW-1:0] ACT_SWITCH = 2'd2;

  localparam logic [StatusW-1:0] ST_READY     = 2'd0;
  localparam logic [StatusW-1:0] ST_RUNNING   = 2'd1;

  localparam logic [RcW-1:0] RC_OK     = 2'd0;
  localparam logic [RcW-1:0] RC_NONE   = 2'd1;
  localparam logic [RcW-1:0] RC_FULL   = 2'd2;
  localparam logic [RcW-1:0] RC_BADIDX = 2'd3;

  // Source of the selected_task / has_task pair of a result
  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_COUNT,
    SEL_CUR,
    SEL_KEEP,
    SEL_NEW
  } sel_e;

  typedef struct packed {
    logic             ld;
    logic             wr_add;
    logic             wr_set;
    logic             rd_cur;
    logic             save_cur_st;
    logic             resume_cur;
    logic             scan_zero;
    logic             scan_cur;
    logic             scan_step;
    logic             found;
    logic             wr_old;
    logic             wr_new;
    logic             emit;
    logic [RcW-1:0]   rc;
    sel_e             sel;
  } rrtp_cmd_t;

  typedef struct packed {
    logic [ActionW-1:0] act;
    logic               full;
    logic               bad_idx;
    logic               empty;
    logic               cur_valid;
    logic               rd_ready;
    logic               last;
  } rrtp_sts_t;

endpackage

@@ src/rrtp_dpath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrtp_dpath
// Task status memory, task count, current task, scan pointer and result regs.
// ----------------------------------------------------------------------------
module rrtp_dpath import rrtp_pkg::*; #(
  parameter int MAX_TASKS = MaxTasksDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [ActionW-1:0]  action_i,
  input  logic [TaskIdxW-1:0] task_index_i,
  input  logic [StatusW-1:0]  new_status_i,
  input  rrtp_cmd_t           cmd_i,
  output rrtp_sts_t           sts_o,
  output logic                done_o,
  output logic [TaskIdxW-1:0] selected_task_o,
  output logic                has_task_o,
  output logic [RcW-1:0]      result_code_o
);

  localparam int IdxW = $clog2(MAX_TASKS);
  localparam int CntW = $clog2(MAX_TASKS + 1);
  localparam int CmpW = (CntW > TaskIdxW) ? CntW : TaskIdxW;

  logic [StatusW-1:0]  mem_q [MAX_TASKS];

  logic [ActionW-1:0]  act_q;
  logic [TaskIdxW-1:0] tidx_q;
  logic [StatusW-1:0]  nst_q;
  logic [StatusW-1:0]  rd_data_q;
  logic [IdxW-1:0]     rd_idx_q;
  logic [StatusW-1:0]  cur_st_q;
  logic [IdxW-1:0]     new_q;

  logic [CntW-1:0]     count_q, count_d;
  logic [IdxW-1:0]     cur_q, cur_d;
  logic                cur_valid_q, cur_valid_d;
  logic [CntW-1:0]     left_q, left_d;
  logic                done_q;
  logic [TaskIdxW-1:0] sel_q;
  logic                has_q;
  logic [RcW-1:0]      rc_q;

  logic [IdxW-1:0]     raddr;
  logic                we;
  logic [IdxW-1:0]     waddr;
  logic [StatusW-1:0]  wdata;
  logic [TaskIdxW-1:0] sel_d;
  logic                has_d;

  // Wrap to task 0 after the last added task
  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] i,
                                               input logic [CntW-1:0] n);
    logic [IdxW-1:0] r;
    if (CntW'(i) == n - CntW'(1)) begin
      r = '0;
    end else begin
      r = i + IdxW'(1);
    end
    return r;
  endfunction

  always_comb begin
    if (cmd_i.rd_cur) begin
      raddr = cur_q;
    end else if (cmd_i.scan_zero) begin
      raddr = '0;
    end else if (cmd_i.scan_cur) begin
      raddr = next_idx(cur_q, count_q);
    end else begin
      raddr = next_idx(rd_idx_q, count_q);
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = cur_q;
    wdata = ST_RUNNING;
    if (cmd_i.wr_add) begin
      we    = 1'b1;
      waddr = IdxW'(count_q);
      wdata = ST_READY;
    end else if (cmd_i.wr_set) begin
      we    = 1'b1;
      waddr = IdxW'(tidx_q);
      wdata = nst_q;
    end else if (cmd_i.resume_cur) begin
      we    = 1'b1;
    end else if (cmd_i.wr_old) begin
      // demote the old task only if it is still running
      we    = cur_valid_q && (cur_st_q == ST_RUNNING);
      wdata = ST_READY;
    end else if (cmd_i.wr_new) begin
      we    = 1'b1;
      waddr = new_q;
    end
  end

  always_comb begin
    count_d     = count_q;
    cur_d       = cur_q;
    cur_valid_d = cur_valid_q;
    left_d      = left_q;
    if (cmd_i.wr_add) begin
      count_d = count_q + CntW'(1);
    end
    if (cmd_i.wr_new) begin
      cur_d       = new_q;
      cur_valid_d = 1'b1;
    end
    if (cmd_i.scan_zero || cmd_i.scan_cur) begin
      left_d = count_q;
    end else if (cmd_i.scan_step) begin
      left_d = left_q - CntW'(1);
    end
  end

  always_comb begin
    sel_d = '0;
    has_d = 1'b0;
    case (cmd_i.sel)
      SEL_NONE: begin
        sel_d = '0;
        has_d = 1'b0;
      end
      SEL_COUNT: begin
        sel_d = TaskIdxW'(count_q);
        has_d = 1'b1;
      end
      SEL_CUR: begin
        sel_d = TaskIdxW'(cur_q);
        has_d = 1'b1;
      end
      SEL_KEEP: begin
        sel_d = cur_valid_q ? TaskIdxW'(cur_q) : '0;
        has_d = cur_valid_q;
      end
      SEL_NEW: begin
        sel_d = TaskIdxW'(new_q);
        has_d = 1'b1;
      end
      default: begin
        sel_d = '0;
        has_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_data_q <= mem_q[raddr];
    rd_idx_q  <= raddr;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld) begin
      act_q  <= action_i;
      tidx_q <= task_index_i;
      nst_q  <= new_status_i;
    end
    if (cmd_i.save_cur_st) begin
      cur_st_q <= rd_data_q;
    end
    if (cmd_i.found) begin
      new_q <= rd_idx_q;
    end
    if (cmd_i.emit) begin
      sel_q <= sel_d;
      has_q <= has_d;
      rc_q  <= cmd_i.rc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cur_q       <= '0;
      cur_valid_q <= 1'b0;
      left_q      <= '0;
      done_q      <= 1'b0;
    end else begin
      count_q     <= count_d;
      cur_q       <= cur_d;
      cur_valid_q <= cur_valid_d;
      left_q      <= left_d;
      done_q      <= cmd_i.emit;
    end
  end

  assign sts_o.act       = act_q;
  assign sts_o.full      = (count_q == CntW'(MAX_TASKS));
  assign sts_o.bad_idx   = (CmpW'(tidx_q) >= CmpW'(count_q));
  assign sts_o.empty     = (count_q == '0);
  assign sts_o.cur_valid = cur_valid_q;
  assign sts_o.rd_ready  = (rd_data_q == ST_READY);
  assign sts_o.last      = (left_q == CntW'(1));

  assign done_o          = done_q;
  assign selected_task_o = sel_q;
  assign has_task_o      = has_q;
  assign result_code_o   = rc_q;

endmodule

@@ src/rrtp_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrtp_ctrl
// Sequencer for add, set-status and the round-robin switch scan.
// ----------------------------------------------------------------------------
module rrtp_ctrl import rrtp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  rrtp_sts_t sts_i,
  output rrtp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_CUR_WAIT,
    S_SCAN,
    S_WR_OLD,
    S_WR_NEW
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rc  = RC_OK;
    cmd_o.sel = SEL_NONE;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.ld = 1'b1;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        state_d = S_IDLE;
        case (sts_i.act)
          ACT_ADD: begin
            cmd_o.emit = 1'b1;
            if (sts_i.full) begin
              cmd_o.rc = RC_FULL;
            end else begin
              cmd_o.wr_add = 1'b1;
              cmd_o.sel    = SEL_COUNT;
            end
          end
          ACT_SET: begin
            cmd_o.emit = 1'b1;
            if (sts_i.bad_idx) begin
              cmd_o.rc = RC_BADIDX;
            end else begin
              cmd_o.wr_set = 1'b1;
            end
          end
          ACT_SWITCH: begin
            if (sts_i.empty) begin
              cmd_o.emit = 1'b1;
              cmd_o.rc   = RC_NONE;
            end else if (sts_i.cur_valid) begin
              cmd_o.rd_cur = 1'b1;
              state_d      = S_CUR_WAIT;
            end else begin
              cmd_o.scan_zero = 1'b1;
              state_d         = S_SCAN;
            end
          end
          default: begin
            cmd_o.emit = 1'b1;
          end
        endcase
      end
      S_CUR_WAIT: begin
        cmd_o.save_cur_st = 1'b1;
        if (sts_i.rd_ready) begin
          // current task was marked ready: resume it
          cmd_o.resume_cur = 1'b1;
          cmd_o.emit       = 1'b1;
          cmd_o.sel        = SEL_CUR;
          state_d          = S_IDLE;
        end else begin
          cmd_o.scan_cur = 1'b1;
          state_d        = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.rd_ready) begin
          cmd_o.found = 1'b1;
          state_d     = S_WR_OLD;
        end else if (sts_i.last) begin
          cmd_o.emit = 1'b1;
          cmd_o.rc   = RC_NONE;
          cmd_o.sel  = SEL_KEEP;
          state_d    = S_IDLE;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_WR_OLD: begin
        cmd_o.wr_old = 1'b1;
        state_d      = S_WR_NEW;
      end
      S_WR_NEW: begin
        cmd_o.wr_new = 1'b1;
        cmd_o.emit   = 1'b1;
        cmd_o.sel    = SEL_NEW;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

@@ src/round_robin_task_picker_top.sv @@
`timescale 1ns / 1ps
// Add, set-status and unknown actions load in S_IDLE and emit in S_EXEC; done_o is registered.
// Switch: the current task resumes from S_CUR_WAIT if marked ready; otherwise the scan,
//   reading one status entry per cycle from the task memory, picks the next ready task.
// Throughput: one item at a time; start is taken again once busy drops.
// Reset (rst_ni low, asynchronous) empties the task table and clears the current task.
// Results are shown for one cycle on done_o; the receiver cannot stall.
// ----------------------------------------------------------------------------
// round_robin_task_picker_top
// Task table with add, set-status and round-robin switch actions.
// ----------------------------------------------------------------------------
module round_robin_task_picker_top import rrtp_pkg::*; #(
  parameter int MAX_TASKS = MaxTasksDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic [ActionW-1:0]  action_i,
  input  logic [TaskIdxW-1:0] task_index_i,
  input  logic [StatusW-1:0]  new_status_i,
  output logic                done_o,
  output logic [TaskIdxW-1:0] selected_task_o,
  output logic                has_task_o,
  output logic [RcW-1:0]      result_code_o
);

  rrtp_cmd_t cmd;
  rrtp_sts_t sts;

  rrtp_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  rrtp_dpath #(
    .MAX_TASKS (MAX_TASKS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .action_i        (action_i),
    .task_index_i    (task_index_i),
    .new_status_i    (new_status_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .done_o          (done_o),
    .selected_task_o (selected_task_o),
    .has_task_o      (has_task_o),
    .result_code_o   (result_code_o)
  );

endmodule
